// ===== rtl/ircd_pkg.sv =====
// ----------------------------------------------------------------------------
// ircd_pkg
// shared types and constants of the ir carrier demodulator
// ----------------------------------------------------------------------------
package ircd_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_GAP_THRESHOLD = 1'b0,
    CFG_MARK_LIMIT    = 1'b1
  } cfg_idx_e;

  // capture channel operation codes
  typedef enum logic [0:0] {
    OP_CAPTURE   = 1'b0,
    OP_GROUP_END = 1'b1
  } op_e;

  localparam logic [30:0] GAP_THRESHOLD_RST = 31'd3000;
  localparam logic [31:0] MARK_LIMIT_RST    = 32'd4000000;
  localparam logic [29:0] PERIOD_MAX        = 30'h3FFF_FFFF;
  localparam logic [37:0] TOTAL_MAX         = 38'h3F_FFFF_FFFF;

  typedef struct packed {
    logic [30:0] gap_threshold;
    logic [31:0] mark_limit;
  } cfg_t;

  // one logical symbol on its way to the period converter
  typedef struct packed {
    logic        is_mark;
    logic [31:0] ticks;
    logic        last;
  } sym_t;

endpackage

// ===== rtl/ircd_in_if.sv =====
// ----------------------------------------------------------------------------
// ircd_in_if
// capture word channel: valid/ready with capture payload
// ----------------------------------------------------------------------------
interface ircd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        carrier_on;
  logic [30:0] capture_duration;

  modport source (output valid, operation, carrier_on, capture_duration, input ready);
  modport sink (input valid, operation, carrier_on, capture_duration, output ready);
endinterface

// ===== rtl/ircd_out_if.sv =====
// ----------------------------------------------------------------------------
// ircd_out_if
// symbol channel: valid/ready with symbol payload
// ----------------------------------------------------------------------------
interface ircd_out_if;
  logic        valid;
  logic        ready;
  logic        is_mark;
  logic [31:0] symbol_ticks;
  logic [29:0] carrier_periods;
  logic [31:0] transmit_word;
  logic [37:0] period_total;
  logic        last_symbol;

  modport source (output valid, is_mark, symbol_ticks, carrier_periods, transmit_word,
                  period_total, last_symbol, input ready);
  modport sink (input valid, is_mark, symbol_ticks, carrier_periods, transmit_word,
                period_total, last_symbol, output ready);
endinterface

// ===== rtl/ircd_demod.sv =====
// ----------------------------------------------------------------------------
// ircd_demod
// merges capture words into marks and spaces, holds back one symbol per group
// ----------------------------------------------------------------------------
module ircd_demod #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ircd_pkg::cfg_t cfg_i,
  ircd_in_if.sink        cap_i,
  output logic           sym_valid_o,
  input  logic           sym_ready_i,
  output ircd_pkg::sym_t sym_o
);
  import ircd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SYMBOLS);

  typedef struct packed {
    logic             hv;
    logic             hm;
    logic [31:0]      ht;
    logic [CNT_W-1:0] cnt;
  } grp_t;

  typedef struct packed {
    grp_t g;
    logic emit;
    sym_t sym;
  } take_t;

  // one symbol offered to the group: may release the held one
  function automatic take_t take_symbol(grp_t g, logic mark, logic [31:0] ticks,
                                        logic [31:0] limit);
    take_t r;
    r.g           = g;
    r.emit        = 1'b0;
    r.sym.is_mark = g.hm;
    r.sym.ticks   = g.ht;
    r.sym.last    = 1'b0;
    if (!(mark && (ticks > limit)) && (g.cnt != MAX_CNT)) begin
      r.emit  = g.hv;
      r.g.hv  = 1'b1;
      r.g.hm  = mark;
      r.g.ht  = ticks;
      r.g.cnt = g.cnt + 1'b1;
    end
    return r;
  endfunction

  grp_t        grp_q, grp_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] pend_q, pend_d;
  logic        open_q, open_d;
  sym_t        slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]  cnt_q, cnt_d;

  logic        accept, pop;
  logic [31:0] dur;
  logic [32:0] gap_sum, acc_sum;
  logic [31:0] gap_sat, acc_sat;
  take_t       a0, a1, a_pass;
  logic        e0, e1;
  sym_t        s0, s1, s_end;

  assign dur     = {1'b0, cap_i.capture_duration};
  assign gap_sum = {1'b0, dur} + {1'b0, pend_q};
  assign gap_sat = gap_sum[32] ? '1 : gap_sum[31:0];
  assign acc_sum = {1'b0, acc_q} + {1'b0, gap_sat};
  assign acc_sat = acc_sum[32] ? '1 : acc_sum[31:0];

  assign pop         = (cnt_q != 2'd0) && sym_ready_i;
  assign cap_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && sym_ready_i);
  assign accept      = cap_i.valid && cap_i.ready;
  assign sym_valid_o = (cnt_q != 2'd0);
  assign sym_o       = slot0_q;

  always_comb begin
    a_pass.g    = grp_q;
    a_pass.emit = 1'b0;
    a_pass.sym  = slot0_q;
    // open mark closes first
    a0 = open_q ? take_symbol(grp_q, 1'b1, acc_q, cfg_i.mark_limit) : a_pass;
    a1 = take_symbol(a0.g, 1'b0, dur, cfg_i.mark_limit);
    s_end.is_mark = a0.g.hm;
    s_end.ticks   = a0.g.ht;
    s_end.last    = 1'b1;

    grp_d  = grp_q;
    acc_d  = acc_q;
    pend_d = pend_q;
    open_d = open_q;
    e0     = 1'b0;
    e1     = 1'b0;
    s0     = a0.sym;
    s1     = a1.sym;

    if (cap_i.operation == OP_GROUP_END) begin
      e0     = a0.emit;
      e1     = a0.g.hv;
      s1     = s_end;
      grp_d  = '0;
      acc_d  = '0;
      pend_d = '0;
      open_d = 1'b0;
    end else if (cap_i.carrier_on) begin
      acc_d  = acc_sat;
      pend_d = '0;
      open_d = 1'b1;
    end else if (cap_i.capture_duration <= cfg_i.gap_threshold) begin
      pend_d = gap_sat;
    end else begin
      e0     = a0.emit;
      e1     = a1.emit;
      grp_d  = a1.g;
      acc_d  = '0;
      pend_d = '0;
      open_d = 1'b0;
    end

    // two-entry symbol buffer, head in slot0
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (accept) begin
      cnt_d   = 2'(e0) + 2'(e1);
      slot0_d = e0 ? s0 : s1;
      slot1_d = s1;
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= '0;
      acc_q  <= '0;
      pend_q <= '0;
      open_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        grp_q  <= grp_d;
        acc_q  <= acc_d;
        pend_q <= pend_d;
        open_q <= open_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("symbol buffer overfilled");

  a_grp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_q.cnt <= MAX_CNT)
    else $error("group symbol count beyond limit");

  a_held_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !grp_q.hv |-> (grp_q.cnt == '0))
    else $error("symbols counted with nothing held");

endmodule

// ===== rtl/ircd_period.sv =====
// ----------------------------------------------------------------------------
// ircd_period
// pipelined tick to carrier period conversion and running period total
// ----------------------------------------------------------------------------
module ircd_period #(
  parameter int CARRIER_TICKS = 1050
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           sym_valid_i,
  output logic           sym_ready_o,
  input  ircd_pkg::sym_t sym_i,
  ircd_out_if.source     sym_o
);
  import ircd_pkg::*;

  localparam longint unsigned RECIP_L = (64'd1 << 33) / 64'(CARRIER_TICKS);
  localparam int RW   = $clog2(RECIP_L + 1);
  localparam int PW   = RW + 34;
  localparam int CT_W = $clog2(CARRIER_TICKS + 1);
  localparam logic [RW-1:0]   RECIP = RW'(RECIP_L);
  localparam logic [CT_W-1:0] CT    = CT_W'(CARRIER_TICKS);
  localparam logic [32:0]     HALF  = 33'(CARRIER_TICKS / 2);

  // stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic r1, r2, r3, r4, r5, ro;

  sym_t           sym1_q, sym2_q, sym3_q, sym4_q, sym5_q;
  logic [32:0]    n1_q, n2_q, n3_q, n4_q;
  logic [16+RW-1:0] pplo_q;
  logic [17+RW-1:0] pphi_q;
  logic [32:0]    qe3_q, qe4_q;
  logic [33:0]    prod4_q;
  logic [29:0]    per5_q;
  logic [37:0]    run_q;

  logic [PW-1:0]  full;
  logic [33:0]    rem, rem_fix, q;
  logic           corr;
  logic [29:0]    per;
  logic [38:0]    tot_sum;
  logic [37:0]    tot_sat;

  logic        o_mark_q, o_last_q;
  logic [31:0] o_ticks_q;
  logic [29:0] o_per_q;
  logic [37:0] o_tot_q;

  assign ro = !vo_q || sym_o.ready;
  assign r5 = !v5_q || ro;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign sym_ready_o = r1;

  assign full    = PW'({pphi_q, 16'b0}) + PW'(pplo_q);
  assign rem     = {1'b0, n4_q} - prod4_q;
  assign corr    = rem >= 34'(CT);
  assign rem_fix = corr ? rem - 34'(CT) : rem;
  assign q       = {1'b0, qe4_q} + 34'(corr);

  always_comb begin
    if (q == '0) begin
      per = 30'd1;
    end else if (q > 34'(PERIOD_MAX)) begin
      per = PERIOD_MAX;
    end else begin
      per = q[29:0];
    end
  end

  assign tot_sum = {1'b0, run_q} + 39'(per5_q);
  assign tot_sat = tot_sum[38] ? TOTAL_MAX : tot_sum[37:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      vo_q  <= 1'b0;
      run_q <= '0;
    end else begin
      if (r1) v1_q <= sym_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
      if (ro) vo_q <= v5_q;
      // total restarts after the group's last symbol
      if (ro && v5_q) run_q <= sym5_q.last ? '0 : tot_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      sym1_q <= sym_i;
      n1_q   <= {1'b0, sym_i.ticks} + HALF;
    end
    if (r2) begin
      sym2_q <= sym1_q;
      n2_q   <= n1_q;
      pplo_q <= {{RW{1'b0}}, n1_q[15:0]} * {{16{1'b0}}, RECIP};
      pphi_q <= {{RW{1'b0}}, n1_q[32:16]} * {{17{1'b0}}, RECIP};
    end
    if (r3) begin
      sym3_q <= sym2_q;
      n3_q   <= n2_q;
      qe3_q  <= 33'(full >> 33);
    end
    if (r4) begin
      sym4_q  <= sym3_q;
      n4_q    <= n3_q;
      qe4_q   <= qe3_q;
      prod4_q <= {1'b0, qe3_q} * {{(34-CT_W){1'b0}}, CT};
    end
    if (r5) begin
      sym5_q <= sym4_q;
      per5_q <= per;
    end
    if (ro && v5_q) begin
      o_mark_q  <= sym5_q.is_mark;
      o_last_q  <= sym5_q.last;
      o_ticks_q <= sym5_q.ticks;
      o_per_q   <= per5_q;
      o_tot_q   <= tot_sat;
    end
  end

  assign sym_o.valid           = vo_q;
  assign sym_o.is_mark         = o_mark_q;
  assign sym_o.symbol_ticks    = o_ticks_q;
  assign sym_o.carrier_periods = o_per_q;
  assign sym_o.transmit_word   = {o_mark_q, o_last_q, o_per_q};
  assign sym_o.period_total    = o_tot_q;
  assign sym_o.last_symbol     = o_last_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (rem_fix < 34'(CT)))
    else $error("reciprocal quotient off by more than one");

  a_total_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && o_last_q) |-> (run_q == '0))
    else $error("period total not restarted after last symbol");

endmodule

// ===== rtl/ir_carrier_demodulator.sv =====
// ----------------------------------------------------------------------------
// ir_carrier_demodulator
// turns raw ir capture words into logical mark and space symbols
// ----------------------------------------------------------------------------
// Capture words (carrier flag, duration in ticks) and group-end events enter on
// cap_i; carrier bursts and the short gaps between them merge into one mark, a
// gap above gap_threshold closes the mark and becomes a space, marks above
// mark_limit are dropped and at most MAX_SYMBOLS symbols are kept per group.
// One symbol is always held back so the final one can carry the end marker.
// Rate: one capture word per cycle while each word yields at most one symbol;
// and the converter takes symbols; a word that yields two symbols (long gap
// after an open mark, or group end with an open mark) holds the input until
// the second drains, since the two-entry symbol buffer passes one symbol a
// cycle into the converter while it is ready. A word's first symbol is held
// in that buffer, then passes the six-stage period converter (split reciprocal
// multiply, correction, clamp, total) to sym_o; a word's second symbol follows it.
// No clearing pass after reset: the block is ready in the first cycle.
module ir_carrier_demodulator #(
  parameter int MAX_SYMBOLS   = 256,
  parameter int CARRIER_TICKS = 1050
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  ircd_pkg::cfg_idx_e cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  ircd_in_if.sink            cap_i,
  ircd_out_if.source         sym_o
);
  import ircd_pkg::*;

  cfg_t cfg_q;
  logic sym_valid, sym_ready;
  sym_t sym;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_threshold <= GAP_THRESHOLD_RST;
      cfg_q.mark_limit    <= MARK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAP_THRESHOLD: cfg_q.gap_threshold <= cfg_data_i[30:0];
        CFG_MARK_LIMIT:    cfg_q.mark_limit    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // mark/space merging and held-symbol bookkeeping
  ircd_demod #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_demod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cap_i       (cap_i),
    .sym_valid_o (sym_valid),
    .sym_ready_i (sym_ready),
    .sym_o       (sym)
  );

  // carrier period rounding, packing and running total
  ircd_period #(
    .CARRIER_TICKS(CARRIER_TICKS)
  ) u_period (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_valid_i (sym_valid),
    .sym_ready_o (sym_ready),
    .sym_i       (sym),
    .sym_o       (sym_o)
  );

endmodule
